// File: rtl/core/xfh_pkg.sv
// Shared types and constants for the XOR-fold hash table with linear probing.
`timescale 1ns / 1ps
`default_nettype none
package xfh_pkg;
	localparam int KeyW = 64;
	localparam int LenW = 4;
	localparam int CfgSizeW = 11;
	localparam int CfgWidthW = 4;
	localparam int CfgDataW = 11;
	localparam int SlotW = 10;
	// The slot count is tied to the 11-bit size register and the 10-bit slot port.
	localparam int TableDepth = 1024;

	localparam logic CFG_TABLE_SIZE = 1'b0;
	localparam logic CFG_KEY_WIDTH = 1'b1;

	typedef struct packed {
		logic [KeyW-1:0] key;
		logic [LenW-1:0] len;
		logic            install;
	} req_t;

	typedef enum logic [2:0] {
		BK_IDLE,
		BK_MOD,
		BK_READ,
		BK_WAIT,
		BK_CHECK,
		BK_DONE,
		BK_CLEAR
	} bk_state_t;
endpackage
`default_nettype wire

// File: rtl/core/xfh_front.sv
// Front end: clips the key to the key width, XOR-folds it and queues the request.
`timescale 1ns / 1ps
`default_nettype none
module xfh_front import xfh_pkg::*; #(
	parameter int KEY_BYTES = 8,
	parameter int HASH_BYTES = 4,
	parameter int QDEPTH = 2
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  push,
	output logic                       full,
	input  wire logic [KeyW-1:0]       key,
	input  wire logic [LenW-1:0]       key_length,
	input  wire logic                  install,
	input  wire logic [CfgWidthW-1:0]  width_eff,
	output logic                       q_valid,
	input  wire logic                  q_take,
	output req_t                       q_req,
	output logic [8*HASH_BYTES-1:0]    q_hash
);
	localparam int PtrW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
	localparam int CntW = $clog2(QDEPTH + 1);

	req_t                    mem_q  [QDEPTH];
	logic [8*HASH_BYTES-1:0] hash_q [QDEPTH];
	logic [PtrW-1:0]         wr_q, rd_q;
	logic [CntW-1:0]         cnt_q;
	logic [LenW-1:0]         len_c;
	logic [KeyW-1:0]         key_c;
	logic [8*HASH_BYTES-1:0] hash_c;
	logic                    do_push, do_pop;

	always_comb begin
		len_c = (key_length > width_eff) ? width_eff : key_length;
		key_c = '0;
		hash_c = '0;
		for (int i = 0; i < KEY_BYTES; i++) begin
			if (LenW'(i) < len_c) begin
				key_c[8*i +: 8] = key[8*i +: 8];
				hash_c[8*(i % HASH_BYTES) +: 8] = hash_c[8*(i % HASH_BYTES) +: 8]
					^ key[8*i +: 8];
			end
		end
	end

	assign full = (cnt_q == CntW'(QDEPTH));
	assign q_valid = (cnt_q != '0);
	assign do_push = push && !full;
	assign do_pop = q_take && q_valid;
	assign q_req = mem_q[rd_q];
	assign q_hash = hash_q[rd_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q] <= '{key: key_c, len: len_c, install: install};
			hash_q[wr_q] <= hash_c;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) wr_q <= (wr_q == PtrW'(QDEPTH-1)) ? '0 : wr_q + 1'b1;
			if (do_pop) rd_q <= (rd_q == PtrW'(QDEPTH-1)) ? '0 : rd_q + 1'b1;
			cnt_q <= cnt_q + CntW'(do_push) - CntW'(do_pop);
		end
	end

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CntW'(QDEPTH)) else $error("front queue count overrun");
	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		full |=> cnt_q != '0) else $error("full queue emptied without pop");
	a_pop_dec: assert property (@(posedge clk) disable iff (!arst_n)
		(do_pop && !do_push) |=> cnt_q == $past(cnt_q) - 1'b1)
		else $error("pop did not shrink queue");
endmodule
`default_nettype wire

// File: rtl/core/xfh_back.sv
// Back end: bit-serial modulo, probe walk through the slot memory, result register.
`timescale 1ns / 1ps
`default_nettype none
module xfh_back import xfh_pkg::*; #(
	parameter int KEY_BYTES = 8,
	parameter int HASH_BYTES = 4
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  q_valid,
	output logic                       q_take,
	input  req_t                       q_req,
	input  wire logic [8*HASH_BYTES-1:0] q_hash,
	input  wire logic [CfgSizeW-1:0]   size_eff,
	input  wire logic [CfgWidthW-1:0]  width_eff,
	output logic                       empty,
	input  wire logic                  pop,
	output logic [SlotW-1:0]           slot,
	output logic                       found,
	output logic                       overflow
);
	localparam int AW = $clog2(TableDepth);
	localparam int NW = $clog2(TableDepth + 1);
	localparam int HW = 8 * HASH_BYTES;
	localparam int SW = 8 * KEY_BYTES;
	localparam int BW = $clog2(HW + 1);

	bk_state_t        st_q, st_d;
	logic [SW-1:0]    mem [TableDepth];
	logic [SW-1:0]    rd_q;
	req_t             req_q;
	logic [HW-1:0]    hash_q;
	logic [NW:0]      rem_q;
	logic [BW-1:0]    bit_q;
	logic [AW-1:0]    idx_q;
	logic [NW-1:0]    n_q;
	logic [NW-1:0]    visits_q;
	logic [SlotW-1:0] slot_q;
	logic             found_q, ovf_q, full_q;
	logic [NW:0]      rem_sh;
	logic [SW-1:0]    kmask, key_ext, wdata;
	logic             match, is_empty, wr_en;
	logic [AW-1:0]    idx_next;

	assign empty = !full_q;
	assign slot = slot_q;
	assign found = found_q;
	assign overflow = ovf_q;
	assign rem_sh = {rem_q[NW-1:0], hash_q[HW-1]};
	assign key_ext = SW'(req_q.key);

	always_comb begin
		kmask = '0;
		for (int i = 0; i < KEY_BYTES; i++)
			if (LenW'(i) < req_q.len) kmask[8*i +: 8] = 8'hFF;
		is_empty = (rd_q[7:0] == 8'h00);
		match = ((rd_q & kmask) == (key_ext & kmask));
		if (req_q.len < width_eff) begin
			for (int i = 0; i < KEY_BYTES; i++)
				if (LenW'(i) == req_q.len && rd_q[8*i +: 8] != 8'h00) match = 1'b0;
		end
		wdata = (rd_q & ~kmask) | (key_ext & kmask);
		idx_next = (NW'(idx_q) + 1'b1 >= n_q) ? '0 : idx_q + 1'b1;
	end

	always_comb begin
		st_d = st_q;
		q_take = 1'b0;
		wr_en = 1'b0;
		unique case (st_q)
			BK_IDLE: if (q_valid && !full_q) begin
				q_take = 1'b1;
				st_d = BK_MOD;
			end
			BK_MOD: if (bit_q == '0) st_d = BK_READ;
			BK_READ: st_d = BK_WAIT;
			BK_WAIT: st_d = BK_CHECK;
			BK_CHECK: begin
				if (is_empty) begin
					wr_en = req_q.install;
					st_d = BK_DONE;
				end else if (match || visits_q + 1'b1 >= n_q) begin
					st_d = BK_DONE;
				end else begin
					st_d = BK_READ;
				end
			end
			BK_DONE: st_d = BK_IDLE;
			BK_CLEAR: if (idx_q == AW'(TableDepth-1)) st_d = BK_IDLE;
			default: st_d = BK_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		if (st_q == BK_CLEAR) mem[idx_q] <= '0;
		else if (wr_en) mem[idx_q] <= wdata;
		rd_q <= mem[idx_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= BK_CLEAR;
			idx_q <= '0;
			full_q <= 1'b0;
			slot_q <= '0;
			found_q <= 1'b0;
			ovf_q <= 1'b0;
		end else begin
			st_q <= st_d;
			if (pop && full_q) full_q <= 1'b0;
			unique case (st_q)
				BK_CLEAR: idx_q <= idx_q + 1'b1;
				BK_IDLE: if (q_take) begin
					req_q <= q_req;
					hash_q <= q_hash;
					rem_q <= '0;
					bit_q <= BW'(HW);
					n_q <= NW'(size_eff);
					visits_q <= '0;
				end
				BK_MOD: begin
					if (bit_q != '0) begin
						rem_q <= (rem_sh >= (NW+1)'(n_q)) ? rem_sh - (NW+1)'(n_q) : rem_sh;
						hash_q <= hash_q << 1;
						bit_q <= bit_q - 1'b1;
					end else begin
						idx_q <= AW'(rem_q);
					end
				end
				BK_CHECK: begin
					if (is_empty || match) begin
						slot_q <= SlotW'(idx_q);
						found_q <= !is_empty;
						ovf_q <= 1'b0;
					end else if (visits_q + 1'b1 >= n_q) begin
						slot_q <= '0;
						found_q <= 1'b0;
						ovf_q <= 1'b1;
					end else begin
						idx_q <= idx_next;
						visits_q <= visits_q + 1'b1;
					end
				end
				BK_DONE: full_q <= 1'b1;
				default: ;
			endcase
		end
	end

	a_take_idle: assert property (@(posedge clk) disable iff (!arst_n)
		q_take |-> (st_q == BK_IDLE && !full_q)) else $error("take while busy");
	a_done_full: assert property (@(posedge clk) disable iff (!arst_n)
		st_q == BK_DONE |=> full_q) else $error("result not registered");
	a_no_wr_clear: assert property (@(posedge clk) disable iff (!arst_n)
		st_q == BK_CLEAR |-> !q_take && !full_q) else $error("activity during clear");
endmodule
`default_nettype wire

// File: rtl/core/xor_fold_hash_linear_probe_core.sv
// Top level of the XOR-fold hash table with linear probing.
// Throughput: one lookup at a time in the back end, taken only once the last result is popped;
// set by the bit-serial modulo (one hash bit a cycle) and the probe step (read, wait, check)
// through the one slot memory.
// Reset: configuration returns to table_size 1021 and key_width 8; the slot memory is
// then cleared, one slot a cycle, while the front queue still takes up to two transactions.
`timescale 1ns / 1ps
`default_nettype none
module xor_fold_hash_linear_probe_core import xfh_pkg::*; #(
	parameter int KEY_BYTES = 8,
	parameter int HASH_BYTES = 4
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_we,
	input  wire logic                 cfg_index,
	input  wire logic [CfgDataW-1:0]  cfg_data,
	input  wire logic                 push,
	output logic                      full,
	input  wire logic [KeyW-1:0]      key,
	input  wire logic [LenW-1:0]      key_length,
	input  wire logic                 install,
	output logic                      empty,
	input  wire logic                 pop,
	output logic [SlotW-1:0]          slot,
	output logic                      found,
	output logic                      overflow
);
	logic [CfgSizeW-1:0]   size_q, size_eff;
	logic [CfgWidthW-1:0]  width_q, width_eff;
	logic                  q_valid, q_take, f_full;
	req_t                  q_req;
	logic [8*HASH_BYTES-1:0] q_hash;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_q <= CfgSizeW'(1021);
			width_q <= CfgWidthW'(8);
		end else begin
			if (cfg_we && cfg_index == CFG_TABLE_SIZE) size_q <= cfg_data;
			if (cfg_we && cfg_index == CFG_KEY_WIDTH) width_q <= cfg_data[CfgWidthW-1:0];
		end
	end

	assign size_eff = (size_q == '0) ? CfgSizeW'(1) :
		(size_q > CfgSizeW'(TableDepth)) ? CfgSizeW'(TableDepth) : size_q;
	assign width_eff = (width_q > CfgWidthW'(KEY_BYTES)) ? CfgWidthW'(KEY_BYTES) : width_q;
	assign full = f_full;

	xfh_front #(.KEY_BYTES(KEY_BYTES), .HASH_BYTES(HASH_BYTES)) u_front (
		.clk, .arst_n, .push, .full(f_full), .key, .key_length, .install,
		.width_eff, .q_valid, .q_take, .q_req, .q_hash
	);

	xfh_back #(.KEY_BYTES(KEY_BYTES), .HASH_BYTES(HASH_BYTES))
	u_back (
		.clk, .arst_n, .q_valid, .q_take, .q_req, .q_hash, .size_eff, .width_eff,
		.empty, .pop, .slot, .found, .overflow
	);

	a_width_eff: assert property (@(posedge clk) disable iff (!arst_n)
		width_eff <= CfgWidthW'(KEY_BYTES) && size_eff != '0)
		else $error("effective configuration out of range");
	a_ovf_slot: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && overflow) |-> (slot == '0 && !found)) else $error("bad overflow result");
	a_one_flag: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> !(found && overflow)) else $error("found with overflow");
endmodule
`default_nettype wire

// File: dv/xor_fold_hash_linear_probe_core_tb.sv
// Self-checking testbench for the XOR-fold hash table core with linear probing.
`timescale 1ns / 1ps
module xor_fold_hash_linear_probe_core_tb;
	import xfh_pkg::*;

	localparam int Depth = 1024;
	localparam int MaxKeyBytes = 8;
	localparam int FoldBytes = 4;
	localparam int CycleLimit = 20000000;

	typedef struct {
		logic [SlotW-1:0] slot;
		logic             found;
		logic             overflow;
	} lookup_t;

	typedef struct {
		logic [KeyW-1:0] key;
		logic [LenW-1:0] len;
		logic            install;
		bit              typed;
		lookup_t         res;
	} row_t;

	typedef struct {
		int size;
		int width;
		int count;
	} phase_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic cfg_index = CFG_TABLE_SIZE;
	logic [CfgDataW-1:0] cfg_data = '0;
	logic push = 1'b0;
	logic full;
	logic [KeyW-1:0] key = '0;
	logic [LenW-1:0] key_length = '0;
	logic install = 1'b0;
	logic empty;
	logic pop = 1'b0;
	logic [SlotW-1:0] slot;
	logic found;
	logic overflow;

	logic [KeyW-1:0] shadow_slots [Depth];
	logic [CfgSizeW-1:0] shadow_size;
	logic [CfgWidthW-1:0] shadow_width;
	lookup_t pending_lookups [$];
	int errors = 0;
	int cycles = 0;
	int pop_mode = 0;
	logic [KeyW-1:0] key_pool [16];

	xor_fold_hash_linear_probe_core uut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .push(push), .full(full), .key(key),
		.key_length(key_length), .install(install), .empty(empty), .pop(pop),
		.slot(slot), .found(found), .overflow(overflow)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	function automatic logic [KeyW-1:0] bytes_mask(int n);
		if (n >= MaxKeyBytes)
			return '1;
		return (64'd1 << (8 * n)) - 64'd1;
	endfunction

	// Looks up a key in the shadow table and, for an install, writes it the way the core should.
	function automatic lookup_t probe_table(logic [KeyW-1:0] k, int len, logic inst);
		int n;
		int w;
		logic [31:0] h;
		int idx;
		logic [KeyW-1:0] s;
		logic [KeyW-1:0] m;
		lookup_t r;
		n = (shadow_size == 0) ? 1 : (shadow_size > Depth) ? Depth : shadow_size;
		w = (shadow_width > MaxKeyBytes) ? MaxKeyBytes : shadow_width;
		if (len > w)
			len = w;
		m = bytes_mask(len);
		k = k & m;
		h = '0;
		for (int i = 0; i < len; i++)
			h ^= 32'(k[8*i +: 8]) << (8 * (i % FoldBytes));
		idx = h % n;
		for (int i = 0; i < n; i++) begin
			s = shadow_slots[idx];
			if (s[7:0] == 8'd0) begin
				if (inst)
					shadow_slots[idx] = (s & ~m) | k;
				r.slot = idx[SlotW-1:0];
				r.found = 1'b0;
				r.overflow = 1'b0;
				return r;
			end
			if ((s & m) == k && (len >= w || s[8*len +: 8] == 8'd0)) begin
				r.slot = idx[SlotW-1:0];
				r.found = 1'b1;
				r.overflow = 1'b0;
				return r;
			end
			idx = (idx + 1 >= n) ? 0 : idx + 1;
		end
		r.slot = '0;
		r.found = 1'b0;
		r.overflow = 1'b1;
		return r;
	endfunction

	// The enable is dropped before the final wait for a clock edge, so that back-to-back writes never
	// drive it twice in one time step.
	task automatic write_reg(logic idx, int value);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value[CfgDataW-1:0];
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == CFG_TABLE_SIZE)
			shadow_size = value[CfgSizeW-1:0];
		else
			shadow_width = value[CfgWidthW-1:0];
		@(posedge clk);
	endtask

	// Holds push high until the core takes the transaction; push stays up afterwards.
	task automatic push_lookup(logic [KeyW-1:0] k, logic [LenW-1:0] len, logic inst,
			bit typed, lookup_t typed_res);
		lookup_t r;
		push <= 1'b1;
		key <= k;
		key_length <= len;
		install <= inst;
		do @(posedge clk); while (full);
		r = probe_table(k, len, inst);
		pending_lookups.push_back(typed ? typed_res : r);
	endtask

	task automatic settle;
		push <= 1'b0;
		while (pending_lookups.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
	endtask

	function automatic logic [KeyW-1:0] rand_key();
		logic [KeyW-1:0] k;
		for (int b = 0; b < MaxKeyBytes; b++)
			k[8*b +: 8] = ($urandom_range(0, 3) == 0) ? 8'd0 : 8'($urandom);
		return k;
	endfunction

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CycleLimit) begin
			$display("xor_fold_hash_linear_probe_core: mismatch");
			$finish;
		end
	end

	// The receiver stalls on its own pattern, with some stretches of constant pop.
	always @(posedge clk) begin
		if ($urandom_range(0, 199) == 0)
			pop_mode <= $urandom_range(0, 3);
		case (pop_mode)
			0: pop <= 1'b1;
			1: pop <= ($urandom_range(0, 3) != 0);
			2: pop <= ($urandom_range(0, 3) == 0);
			default: pop <= cycles[2];
		endcase
	end

	always @(posedge clk) begin
		lookup_t e;
		if (arst_n && pop && !empty) begin
			if (pending_lookups.size() == 0) begin
				$error("result with nothing pending: slot %0d", slot);
				errors++;
			end else begin
				e = pending_lookups.pop_front();
				if (slot !== e.slot) begin
					$error("slot: expected %0d, got %0d", e.slot, slot);
					errors++;
				end
				if (found !== e.found) begin
					$error("found: expected %0d, got %0d", e.found, found);
					errors++;
				end
				if (overflow !== e.overflow) begin
					$error("overflow: expected %0d, got %0d", e.overflow, overflow);
					errors++;
				end
			end
		end
	end

	initial begin
		row_t rows [$];
		phase_t phases [$];
		lookup_t none;
		int burst;
		logic [KeyW-1:0] k;
		logic [LenW-1:0] len;
		none = '{slot: '0, found: 1'b0, overflow: 1'b0};
		// Directed rows after reset: table_size 1021, key_width 8, table empty.
		rows = '{
			'{64'h0, 4'd0, 1'b1, 1, '{10'd0, 1'b0, 1'b0}},
			'{64'h1, 4'd1, 1'b1, 1, '{10'd1, 1'b0, 1'b0}},
			'{64'h1, 4'd1, 1'b0, 1, '{10'd1, 1'b1, 1'b0}},
			'{64'hFFFF_FFFF_FFFF_FFFF, 4'd8, 1'b1, 1, '{10'd0, 1'b0, 1'b0}},
			'{64'hFFFF_FFFF_FFFF_FFFF, 4'd15, 1'b0, 1, '{10'd0, 1'b1, 1'b0}},
			'{64'h0, 4'd0, 1'b0, 1, '{10'd2, 1'b0, 1'b0}},
			'{64'hFFFF_FFFF_FFFF_FF00, 4'd8, 1'b1, 0, none},
			'{64'hFFFF_FFFF_FFFF_FF00, 4'd8, 1'b0, 0, none},
			'{64'h0102_0304_0506_0708, 4'd8, 1'b1, 0, none},
			'{64'h0102_0304_0506_0708, 4'd4, 1'b0, 0, none},
			'{64'h0000_0000_0506_0708, 4'd4, 1'b1, 0, none},
			'{64'h0102_0304_0506_0708, 4'd4, 1'b0, 0, none},
			'{64'hDEAD_BEEF_0000_0001, 4'd7, 1'b1, 0, none},
			'{64'hDEAD_BEEF_0000_0001, 4'd9, 1'b0, 0, none},
			'{64'h8000_0000_0000_0041, 4'd8, 1'b0, 0, none}
		};
		phases = '{
			'{2, 1, 60}, '{0, 8, 30}, '{7, 3, 120}, '{2047, 8, 150}, '{1024, 15, 100},
			'{13, 0, 40}, '{31, 2, 150}, '{1021, 8, 150}, '{3, 8, 50}
		};
		for (int i = 0; i < Depth; i++)
			shadow_slots[i] = '0;
		shadow_size = 11'd1021;
		shadow_width = 4'd8;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		foreach (rows[i])
			push_lookup(rows[i].key, rows[i].len, rows[i].install, rows[i].typed,
				rows[i].res);
		settle();

		foreach (phases[p]) begin
			write_reg(CFG_TABLE_SIZE, phases[p].size);
			write_reg(CFG_KEY_WIDTH, phases[p].width);
			foreach (key_pool[j])
				key_pool[j] = rand_key();
			burst = 0;
			for (int i = 0; i < phases[p].count; i++) begin
				if (burst == 0) begin
					push <= 1'b0;
					repeat ($urandom_range(1, 12)) @(posedge clk);
					burst = ($urandom_range(0, 3) == 0) ? 40 : $urandom_range(1, 8);
				end
				burst--;
				// Mostly reuse a small pool so that lookups hit installed entries.
				k = ($urandom_range(0, 3) != 0) ? key_pool[$urandom_range(0, 15)]
					: rand_key();
				len = ($urandom_range(0, 7) == 0) ? 4'($urandom_range(0, 15))
					: 4'($urandom_range(1, 8));
				push_lookup(k, len, 1'($urandom), 0, none);
			end
			settle();
		end

		repeat (50) @(posedge clk);
		if (errors == 0)
			$display("xor_fold_hash_linear_probe_core: match");
		else
			$display("xor_fold_hash_linear_probe_core: mismatch");
		$finish;
	end
endmodule

// File: xor_fold_hash_linear_probe_core.f
rtl/core/xfh_pkg.sv
rtl/core/xfh_front.sv
rtl/core/xfh_back.sv
rtl/core/xor_fold_hash_linear_probe_core.sv
dv/xor_fold_hash_linear_probe_core_tb.sv
